// ===== sv/gnmc_pkg.sv =====
// gnmc_pkg: shared types, constants and the neighbor offset table
// for the grid neighbor mark counter; no dependencies
package gnmc_pkg;

  localparam int MAX_DIM_DEF = 32;
  localparam int IDX_W       = 10;
  localparam int DIM_REG_W   = 6;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
  localparam int NB_NUM      = 8;
  localparam int NB_K_W      = $clog2(NB_NUM);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [DIM_REG_W-1:0] GRID_ROWS_RST = 6'd10;
  localparam logic [DIM_REG_W-1:0] GRID_COLS_RST = 6'd10;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] cell_index;
    logic             mark_value;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] neighbor_cells;
    logic [CNT_W-1:0] neighbor_marks;
    logic             index_error;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    logic             is_query;
    logic             in_map;
    logic [IDX_W-1:0] cell_index;
    logic             mark_value;
  } cmd_t;

  // row and column offsets of neighbor k, each biased by one (0..2)
  function automatic logic [3:0] nb_offs(input logic [NB_K_W-1:0] k);
    logic [3:0] o;
    unique case (k)
      3'd0:    o = {2'd0, 2'd0};
      3'd1:    o = {2'd0, 2'd1};
      3'd2:    o = {2'd0, 2'd2};
      3'd3:    o = {2'd1, 2'd0};
      3'd4:    o = {2'd1, 2'd2};
      3'd5:    o = {2'd2, 2'd0};
      3'd6:    o = {2'd2, 2'd1};
      3'd7:    o = {2'd2, 2'd2};
      default: o = {2'd1, 2'd1};
    endcase
    return o;
  endfunction

endpackage

// ===== sv/gnmc_front.sv =====
// gnmc_front: accepts input beats, classifies them and queues commands
// depends on gnmc_pkg
module gnmc_front import gnmc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  input  logic     hold_off,
  input  logic     cmd_pop,
  output logic     cmd_empty,
  output cmd_t     cmd
);

  localparam int MAP_DEPTH = MAX_DIM * MAX_DIM;

  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;
  cmd_t                  new_cmd;

  assign full      = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH)) || hold_off;
  assign cmd_empty = (cnt_r == '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && !cmd_empty;

  always_comb begin
    new_cmd.is_query   = (in_data.op == OP_QUERY);
    new_cmd.in_map     = (32'(in_data.cell_index) < MAP_DEPTH);
    new_cmd.cell_index = in_data.cell_index;
    new_cmd.mark_value = in_data.mark_value;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== sv/gnmc_div.sv =====
// gnmc_div: restoring divider, one quotient bit per cycle
// depends on gnmc_pkg
module gnmc_div import gnmc_pkg::*; #(
  parameter int DW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IDX_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [IDX_W-1:0] quotient,
  output logic [DW-1:0]    remainder
);

  localparam int STEP_W = $clog2(IDX_W + 1);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [IDX_W-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     dvs_r, dvs_nxt;
  logic [DW:0]       rem_sh;
  logic [DW:0]       rem_sub;
  logic              fits;

  assign rem_sh  = {rem_r, quo_r[IDX_W-1]};
  assign fits    = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      step_nxt = STEP_W'(IDX_W);
      busy_nxt = 1'b1;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[IDX_W-2:0], fits};
      rem_nxt  = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/gnmc_back.sv =====
// gnmc_back: mark map memory, clearing pass, query sequencer and result register
// depends on gnmc_pkg and gnmc_div
module gnmc_back import gnmc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [DIM_REG_W-1:0] grid_rows,
  input  logic [DIM_REG_W-1:0] grid_cols,
  input  logic                 cmd_empty,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  output logic                 clearing,
  input  logic                 pop,
  output logic                 empty,
  output out_item_t            out_data
);

  localparam int DW        = $clog2(MAX_DIM + 1);
  localparam int MAP_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int SW        = 2 * DW + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_RES   = 3'd6;

  function automatic logic [DW-1:0] dim_clamp(input logic [DIM_REG_W-1:0] v);
    logic [DW-1:0] d;
    if (v == '0) begin
      d = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = DW'(MAX_DIM);
    end else begin
      d = DW'(v);
    end
    return d;
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [DW-1:0]    rows_r, rows_nxt;
  logic [DW-1:0]    cols_r, cols_nxt;
  logic [DW-1:0]    row_r, row_nxt;
  logic [DW-1:0]    col_r, col_nxt;
  logic [NB_K_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] cells_r, cells_nxt;
  logic [CNT_W-1:0] marks_r, marks_nxt;
  logic             err_r, err_nxt;
  logic             rd_vld_r;
  logic             out_vld_r, out_vld_nxt;
  out_item_t        out_r, out_nxt;

  logic             mark_mem [MAP_DEPTH];
  logic             mem_we, mem_wd, mem_re, mem_rd_r;
  logic [AW-1:0]    mem_wa, mem_ra;

  logic             div_start, div_done;
  logic [IDX_W-1:0] div_quo;
  logic [DW-1:0]    div_rem;

  logic [3:0]       offs;
  logic [DW:0]      r_p, c_p;
  logic [DW-1:0]    nb_r, nb_c;
  logic             nb_in;
  logic [2*DW-1:0]  nb_prod;
  logic [SW-1:0]    nb_sum;
  logic [2*DW-1:0]  area;
  logic             out_free;

  gnmc_div #(.DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (idx_r),
    .divisor   (cols_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // neighbor position, biased by one so an off-grid step shows as 0 or above the edge
  assign offs    = nb_offs(k_r);
  assign r_p     = {1'b0, row_r} + (DW+1)'(offs[3:2]);
  assign c_p     = {1'b0, col_r} + (DW+1)'(offs[1:0]);
  assign nb_in   = (r_p != '0) && (r_p <= {1'b0, rows_r}) &&
                   (c_p != '0) && (c_p <= {1'b0, cols_r});
  assign nb_r    = DW'(r_p - 1'b1);
  assign nb_c    = DW'(c_p - 1'b1);
  assign nb_prod = cols_r * nb_r;
  assign nb_sum  = SW'(nb_prod) + SW'(nb_c);
  assign area    = rows_r * cols_r;

  assign out_free = !out_vld_r || pop;
  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    idx_nxt      = idx_r;
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    k_nxt        = k_r;
    cells_nxt    = cells_r;
    marks_nxt    = marks_r;
    err_nxt      = err_r;
    out_vld_nxt  = out_vld_r && !pop;
    out_nxt      = out_r;
    cmd_pop      = 1'b0;
    div_start    = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = clr_addr_r;
    mem_wd       = 1'b0;
    mem_re       = 1'b0;
    mem_ra       = nb_sum[AW-1:0];

    if (rd_vld_r && mem_rd_r) begin
      marks_nxt = marks_r + 1'b1;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.is_query) begin
            idx_nxt   = cmd.cell_index;
            rows_nxt  = dim_clamp(grid_rows);
            cols_nxt  = dim_clamp(grid_cols);
            cells_nxt = '0;
            marks_nxt = '0;
            k_nxt     = '0;
            state_nxt = ST_CHECK;
          end else begin
            // writes past the map are dropped
            mem_we = cmd.in_map;
            mem_wa = AW'(cmd.cell_index);
            mem_wd = cmd.mark_value;
          end
        end
      end
      ST_CHECK: begin
        err_nxt = (32'(idx_r) >= 32'(area));
        if (32'(idx_r) >= 32'(area)) begin
          state_nxt = ST_RES;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          row_nxt   = div_quo[DW-1:0];
          col_nxt   = div_rem;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        mem_re = nb_in;
        if (nb_in) begin
          cells_nxt = cells_r + 1'b1;
        end
        k_nxt = k_r + 1'b1;
        if (k_r == NB_K_W'(NB_NUM - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          out_vld_nxt            = 1'b1;
          out_nxt.neighbor_cells = err_r ? '0 : cells_r;
          out_nxt.neighbor_marks = err_r ? '0 : marks_r;
          out_nxt.index_error    = err_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      out_vld_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      out_vld_r  <= out_vld_nxt;
      rd_vld_r   <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    rows_r  <= rows_nxt;
    cols_r  <= cols_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    k_r     <= k_nxt;
    cells_r <= cells_nxt;
    marks_r <= marks_nxt;
    err_r   <= err_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mark_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= mark_mem[mem_ra];
    end
  end

  assign empty    = !out_vld_r;
  assign out_data = out_r;

endmodule

// ===== sv/grid_neighbor_mark_count.sv =====
// channel   dir   handshake             payload
// input     in    push / full           in_data  (op, cell_index, mark_value)
// result    out   pop / empty           out_data (neighbor_cells, neighbor_marks, index_error)
// config    in    cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// a write beat is done as the back end pops it; a query's time is set by the
// 10-step divider that splits the index and the single read port that walks the
// eight neighbors one a cycle, and a query whose index is off the grid skips both
// after reset the mark map is swept to zero over all MAX_DIM*MAX_DIM entries (1024
// by default), with full held high; config writes are taken throughout
// a four-entry command queue decouples intake from the back end, and the result
// register lets the next query run while a result waits for pop
// top level of the grid neighbor mark counter; depends on gnmc_pkg,
// gnmc_front and gnmc_back
module grid_neighbor_mark_count import gnmc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_data,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_REG_W-1:0] cfg_wdata
);

  logic [DIM_REG_W-1:0] grid_rows_r, grid_rows_nxt;
  logic [DIM_REG_W-1:0] grid_cols_r, grid_cols_nxt;
  logic                 cmd_pop, cmd_empty, clearing;
  cmd_t                 cmd;

  // config registers keep the raw bits; clamping happens at query time
  assign cfg_ready = 1'b1;

  always_comb begin
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_GRID_ROWS) begin
        grid_rows_nxt = cfg_wdata;
      end else if (cfg_index == CFG_GRID_COLS) begin
        grid_cols_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_ROWS_RST;
      grid_cols_r <= GRID_COLS_RST;
    end else begin
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
    end
  end

  // front: intake, classification, command queue
  gnmc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .hold_off  (clearing),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  // back: map, divider, neighbor walk, result register
  gnmc_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grid_rows (grid_rows_r),
    .grid_cols (grid_cols_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule

// ===== sv/gnmc_chk.sv =====
// gnmc_chk: port-level checks of the grid neighbor mark counter, bound to the top
// depends on gnmc_pkg
module gnmc_chk import gnmc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input out_item_t            out_data
);

  // the clearing pass holds off intake right after reset
  a_clear_blocks: assert property (@(posedge clk) $rose(rst_n) |-> full)
    else $error("input accepted during map clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  a_marks_le_cells: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.neighbor_marks <= out_data.neighbor_cells))
    else $error("more marks than neighbor cells");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.index_error) |->
      (out_data.neighbor_cells == '0 && out_data.neighbor_marks == '0))
    else $error("error result with nonzero counts");

  a_cells_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.neighbor_cells <= CNT_W'(NB_NUM)))
    else $error("neighbor count above eight");

endmodule

bind grid_neighbor_mark_count gnmc_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_data  (out_data)
);

// ===== dv/neighbor_count_checker.sv =====
// neighbor_count_checker: watches the input, result and config channels of
// grid_neighbor_mark_count, predicts each query's neighbor counts and compares
// depends on gnmc_pkg
module neighbor_count_checker import gnmc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  in_item_t             in_data,
  input  logic                 empty,
  input  logic                 pop,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_REG_W-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   waiting,
  output int                   checked,
  output int                   off_grid
);

  localparam int MAP_DEPTH = MAX_DIM * MAX_DIM;

  logic                 mark_map [MAP_DEPTH];
  logic [DIM_REG_W-1:0] rows_reg;
  logic [DIM_REG_W-1:0] cols_reg;
  out_item_t            expected_tallies [$];

  // zero counts as one, anything past MAX_DIM as MAX_DIM
  function automatic int usable_dim(input logic [DIM_REG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic out_item_t tally_neighbors(input logic [IDX_W-1:0] idx);
    out_item_t t;
    int rows, cols, row, col, r, c, n, cells, marks, dr, dc;
    t = '0;
    cells = 0;
    marks = 0;
    rows = usable_dim(rows_reg);
    cols = usable_dim(cols_reg);
    if (int'(idx) >= rows * cols) begin
      t.index_error = 1'b1;
      return t;
    end
    row = int'(idx) / cols;
    col = int'(idx) % cols;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        r = row + dr;
        c = col + dc;
        if ((dr != 0 || dc != 0) && r >= 0 && c >= 0 && r < rows && c < cols) begin
          cells++;
          n = c + cols * r;
          if (n < MAP_DEPTH && mark_map[n]) marks++;
        end
      end
    end
    t.neighbor_cells = CNT_W'(cells);
    t.neighbor_marks = CNT_W'(marks);
    return t;
  endfunction

  task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (mark_map[i]) mark_map[i] = 1'b0;
      rows_reg = GRID_ROWS_RST;
      cols_reg = GRID_COLS_RST;
      expected_tallies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_ROWS: rows_reg = cfg_wdata;
          CFG_GRID_COLS: cols_reg = cfg_wdata;
          default: ;
        endcase
      end
      // result side first: a result can never leave in the beat its query enters
      if (pop && !empty) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: result with nothing expected, got %p", $time, out_data);
          fail_count++;
        end else begin
          want = expected_tallies.pop_front();
          compare_field("neighbor_cells", want.neighbor_cells, out_data.neighbor_cells);
          compare_field("neighbor_marks", want.neighbor_marks, out_data.neighbor_marks);
          compare_field("index_error", CNT_W'(want.index_error),
                        CNT_W'(out_data.index_error));
          checked++;
          if (want.index_error) off_grid++;
        end
      end
      if (push && !full) begin
        if (in_data.op == OP_QUERY) begin
          expected_tallies.push_back(tally_neighbors(in_data.cell_index));
        end else if (int'(in_data.cell_index) < MAP_DEPTH) begin
          mark_map[in_data.cell_index] = in_data.mark_value;
        end
      end
    end
    waiting = expected_tallies.size();
  end

endmodule

// ===== dv/testbench.sv =====
// testbench: stimulus and verdict for grid_neighbor_mark_count; prediction and
// comparison live in neighbor_count_checker; depends on gnmc_pkg
module testbench;
  import gnmc_pkg::*;

  // indexes with no register behind them, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int RAND_PHASES  = 15;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 150;     // a few queries' worth of back-end time
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  in_item_t             in_data = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_ROWS;
  logic [DIM_REG_W-1:0] cfg_wdata = '0;

  int fail_count, tallies_waiting, results_checked, results_off_grid;
  int tx_idle_pct, rx_idle_pct;
  int sent_beats, geometries, grid_area, cycle_count;
  int rx_hold_left;
  bit rx_hold_request, rx_hold_done;

  // raw register values for the first random phases: corners of the range,
  // zero and oversize values that the block has to clamp
  int fixed_rows [7] = '{32, 1, 1, 32, 0, 63, 33};
  int fixed_cols [7] = '{32, 1, 32, 1, 63, 0, 5};

  grid_neighbor_mark_count uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  neighbor_count_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .waiting   (tallies_waiting),
    .checked   (results_checked),
    .off_grid  (results_off_grid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog, covers reset sweep, all idling patterns and the hold-off
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, tallies_waiting);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random pop, plus one long hold-off once the stimulus asks for it
  always @(posedge clk) begin
    if (rx_hold_request && !rx_hold_done) begin
      rx_hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // one input beat, with random idle cycles ahead of it; push stays high
  // across back-to-back beats
  task automatic send_beat(input logic op, input int idx, input logic mark);
    in_item_t it;
    it.op         = op;
    it.cell_index = IDX_W'(idx);
    it.mark_value = mark;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_beats++;
  endtask

  // wait until every query has been answered, then let trailing writes retire
  task automatic drain_block;
    push <= 1'b0;
    @(posedge clk);
    while (tallies_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high between writes of one group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= DIM_REG_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_geometry(input int rows, input int cols, input bit with_spare);
    int rows_used, cols_used;
    drain_block();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    if (with_spare) begin
      write_reg(CFG_SPARE_A, $urandom_range(0, 63));
      write_reg(CFG_SPARE_B, 63);
    end
    cfg_valid <= 1'b0;
    // area for shaping the random indexes only
    rows_used = (rows == 0) ? 1 : ((rows > MAX_DIM_DEF) ? MAX_DIM_DEF : rows);
    cols_used = (cols == 0) ? 1 : ((cols > MAX_DIM_DEF) ? MAX_DIM_DEF : cols);
    grid_area = rows_used * cols_used;
    geometries++;
  endtask

  initial begin
    int phase, third, k, idx;
    logic is_query;
    tx_idle_pct = 25;
    rx_idle_pct = 85;
    grid_area   = 100;
    geometries  = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset geometry 10 x 10, map empty
    send_beat(OP_QUERY, 0, 1'b0);      // corner with nothing marked
    send_beat(OP_WRITE, 1, 1'b1);
    send_beat(OP_WRITE, 10, 1'b1);
    send_beat(OP_WRITE, 11, 1'b1);
    send_beat(OP_QUERY, 0, 1'b0);      // corner, all three neighbors marked
    send_beat(OP_QUERY, 55, 1'b1);     // interior, mark bit ignored on a query
    send_beat(OP_QUERY, 99, 1'b0);     // far corner
    send_beat(OP_QUERY, 9, 1'b0);      // top right corner
    send_beat(OP_QUERY, 50, 1'b0);     // left edge
    send_beat(OP_WRITE, 1023, 1'b1);   // outside the grid, still stored
    send_beat(OP_QUERY, 100, 1'b0);    // just past the grid
    send_beat(OP_QUERY, 1023, 1'b0);   // top of the index range
    send_beat(OP_WRITE, 11, 1'b0);     // clear a mark
    send_beat(OP_QUERY, 0, 1'b0);
    send_beat(OP_QUERY, 12, 1'b0);

    // unmapped register indexes, geometry must stay 10 x 10
    apply_geometry(10, 10, 1'b1);
    send_beat(OP_QUERY, 1, 1'b0);
    // zero registers act as a 1 x 1 grid
    apply_geometry(0, 0, 1'b0);
    send_beat(OP_QUERY, 0, 1'b0);
    send_beat(OP_QUERY, 1, 1'b0);
    // oversize registers act as 32 x 32, the cell written off-grid now counts
    apply_geometry(63, 63, 1'b0);
    send_beat(OP_QUERY, 1022, 1'b0);
    send_beat(OP_QUERY, 1023, 1'b0);
    send_beat(OP_QUERY, 0, 1'b0);
    // single row, then single column
    apply_geometry(1, 32, 1'b0);
    send_beat(OP_QUERY, 5, 1'b0);
    apply_geometry(32, 1, 1'b0);
    send_beat(OP_QUERY, 5, 1'b0);

    // random phases, each under its own geometry
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      third = phase * 3 / RAND_PHASES;
      if (phase < 7) begin
        apply_geometry(fixed_rows[phase], fixed_cols[phase], phase % 4 == 0);
      end else begin
        apply_geometry($urandom_range(0, 63), $urandom_range(0, 63), phase % 4 == 0);
      end
      // sender idle / receiver idle, swapped, then none at all
      case (third)
        0: begin
          tx_idle_pct = 25;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 25;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // first no-idle phase: receiver stops so the block backs up
          rx_hold_request = 1'b1;
        end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        is_query = ($urandom_range(0, 99) < 60);
        if ($urandom_range(0, 99) < 85) idx = $urandom_range(0, grid_area - 1);
        else idx = $urandom_range(0, 1023);
        send_beat(is_query ? OP_QUERY : OP_WRITE, idx, $urandom_range(0, 99) < 60);
      end
    end

    drain_block();
    $display("%0d input beats over %0d grid geometries, swapped idling and one long hold-off",
             sent_beats, geometries);
    $display("%0d neighbor counts checked, %0d of them off-grid queries",
             results_checked, results_off_grid);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gnmc_pkg.sv
sv/gnmc_front.sv
sv/gnmc_div.sv
sv/gnmc_back.sv
sv/grid_neighbor_mark_count.sv
sv/gnmc_chk.sv
dv/neighbor_count_checker.sv
dv/testbench.sv
